FILE: design/rpnh_pkg.sv
`timescale 1ns / 1ps
package rpnh_pkg;
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int T_BITS     = 48;
    // cross products of 33-bit differences need 67 bits signed
    localparam int CROSS_BITS = 2 * (COORD_BITS + 1) + 1;
    // dividend of t: |nt| << FRAC_BITS
    localparam int NUM_BITS   = CROSS_BITS + FRAC_BITS;
    localparam int LEN2_BITS  = 2 * COORD_BITS + 1;
    localparam int LEN_BITS   = (LEN2_BITS + 1) / 2;
    localparam logic [T_BITS-1:0] T_MAX = {T_BITS{1'b1}};

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // latch ray/edge, form differences
        OP_MUL,      // one product step
        OP_CLASSIFY, // sign fix and hit test
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,   // compare t with best
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_FINAL_MUL,
        OP_OUTPUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] sel;   // product index for OP_MUL / OP_FINAL_MUL
    } cmd_t;

    typedef struct packed {
        logic accept_edge; // edge passes the hit test
        logic div_done;
        logic sqrt_done;
        logic any_hit;
    } stat_t;
endpackage

FILE: design/rpnh_datapath.sv
`timescale 1ns / 1ps
module rpnh_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rpnh_pkg::cmd_t                      cmd,
    output rpnh_pkg::stat_t                     stat,
    input  logic [8*rpnh_pkg::COORD_BITS-1:0]   in_data,
    input  logic                                in_first,
    output logic [3*rpnh_pkg::COORD_BITS:0]     out_data
);
    localparam int CB = rpnh_pkg::COORD_BITS;
    localparam int XB = rpnh_pkg::CROSS_BITS;
    localparam int NB = rpnh_pkg::NUM_BITS;
    localparam int TB = rpnh_pkg::T_BITS;
    localparam int LB = rpnh_pkg::LEN_BITS;
    localparam int L2 = rpnh_pkg::LEN2_BITS;
    localparam int FB = rpnh_pkg::FRAC_BITS;
    localparam int HB = rpnh_pkg::T_BITS / 2;
    localparam int CNTB = $clog2(NB + 1);

    logic signed [CB-1:0] org_x_reg, org_y_reg, dir_x_reg, dir_y_reg;
    logic signed [CB:0]   seg_x_reg, seg_y_reg, q_x_reg, q_y_reg;
    logic [TB-1:0]        best_reg;
    logic                 any_hit_reg;
    logic signed [XB-1:0] p_reg [8];
    logic signed [XB-1:0] den_reg, nt_reg, nu_reg;
    logic [NB-1:0]        num_reg, quo_reg;
    logic [XB:0]          rem_reg;
    logic [CNTB-1:0]      cnt_reg;
    logic [L2-1:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [LB-1:0]        len_reg;
    logic signed [TB+CB+1:0] fin_reg [3];
    logic [3*CB:0]        out_reg;

    // multiplier operand selection: one signed product per step
    // slots 6 and 7 hold the squared direction components
    logic signed [CB:0]     ma, mb;
    logic signed [2*CB+1:0] mprod;
    always_comb begin
        unique case (cmd.sel)
            3'd0: begin ma = (CB+1)'(dir_x_reg); mb = seg_y_reg; end
            3'd1: begin ma = seg_x_reg; mb = (CB+1)'(dir_y_reg); end
            3'd2: begin ma = q_x_reg; mb = seg_y_reg; end
            3'd3: begin ma = seg_x_reg; mb = q_y_reg; end
            3'd4: begin ma = q_x_reg; mb = (CB+1)'(dir_y_reg); end
            3'd6: begin ma = (CB+1)'(dir_x_reg); mb = (CB+1)'(dir_x_reg); end
            3'd7: begin ma = (CB+1)'(dir_y_reg); mb = (CB+1)'(dir_y_reg); end
            default: begin ma = (CB+1)'(dir_x_reg); mb = q_y_reg; end
        endcase
        // sign extension of the direction operands
        if (cmd.sel == 3'd0 || cmd.sel == 3'd5) ma = {dir_x_reg[CB-1], dir_x_reg};
        if (cmd.sel == 3'd1 || cmd.sel == 3'd4) mb = {dir_y_reg[CB-1], dir_y_reg};
        mprod = ma * mb;
    end

    // final stage multiplier: one half of t (sel[0]) times direction or length
    logic signed [HB:0]      fa;
    logic signed [CB:0]      fbm;
    logic signed [HB+CB+1:0] fprod;
    always_comb begin
        fa = cmd.sel[0] ? {1'b0, best_reg[TB-1:HB]} : {1'b0, best_reg[HB-1:0]};
        unique case (cmd.sel[2:1])
            2'd0:    fbm = {dir_x_reg[CB-1], dir_x_reg};
            2'd1:    fbm = {dir_y_reg[CB-1], dir_y_reg};
            default: fbm = (CB+1)'({1'b0, len_reg[CB-1:0]});
        endcase
        fprod = fa * fbm;
    end

    logic signed [XB-1:0] den_c, nt_c, nu_c;
    logic                 neg_c;
    always_comb begin
        den_c = p_reg[0] - p_reg[1];
        nt_c  = p_reg[2] - p_reg[3];
        nu_c  = p_reg[4] - p_reg[5];
        neg_c = den_c[XB-1];
        if (neg_c) begin
            den_c = -den_c; nt_c = -nt_c; nu_c = -nu_c;
        end
    end

    // restoring division step
    logic [XB:0] rem_sh, rem_sub;
    always_comb begin
        rem_sh  = {rem_reg[XB-1:0], num_reg[NB-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    logic [L2-1:0] sq_trial;
    assign sq_trial = sq_res_reg + sq_bit_reg;

    logic [TB-1:0] t_sat;
    assign t_sat = (|quo_reg[NB-1:TB]) ? rpnh_pkg::T_MAX : quo_reg[TB-1:0];

    // saturation helpers
    function automatic logic [CB-1:0] sat_s(input logic signed [TB+CB+1:0] v);
        logic signed [TB+CB+1:0] mx, mn;
        mx = (TB+CB+2)'(signed'({1'b0, {(CB-1){1'b1}}}));
        mn = -mx - 1;
        if (v > mx) return {1'b0, {(CB-1){1'b1}}};
        if (v < mn) return {1'b1, {(CB-1){1'b0}}};
        return v[CB-1:0];
    endfunction

    logic signed [TB+CB+1:0] hx, hy, hd;
    always_comb begin
        hx = (fin_reg[0] >>> FB) + (TB+CB+2)'(org_x_reg);
        hy = (fin_reg[1] >>> FB) + (TB+CB+2)'(org_y_reg);
        hd = fin_reg[2] >>> FB;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0; org_y_reg <= '0; dir_x_reg <= '0; dir_y_reg <= '0;
            best_reg <= rpnh_pkg::T_MAX;
            any_hit_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            unique case (cmd.op)
                rpnh_pkg::OP_LOAD: begin
                    logic signed [CB-1:0] ox, oy, ax, ay;
                    ax = in_data[4*CB +: CB];
                    ay = in_data[5*CB +: CB];
                    ox = in_first ? in_data[0 +: CB] : org_x_reg;
                    oy = in_first ? in_data[CB +: CB] : org_y_reg;
                    if (in_first) begin
                        org_x_reg <= in_data[0 +: CB];
                        org_y_reg <= in_data[CB +: CB];
                        dir_x_reg <= in_data[2*CB +: CB];
                        dir_y_reg <= in_data[3*CB +: CB];
                        any_hit_reg <= 1'b0;
                        best_reg <= rpnh_pkg::T_MAX;
                    end
                    seg_x_reg <= $signed(in_data[6*CB +: CB]) - ax;
                    seg_y_reg <= $signed(in_data[7*CB +: CB]) - ay;
                    q_x_reg   <= ax - ox;
                    q_y_reg   <= ay - oy;
                end
                rpnh_pkg::OP_MUL: p_reg[cmd.sel] <= XB'(mprod);
                rpnh_pkg::OP_CLASSIFY: begin
                    den_reg <= den_c; nt_reg <= nt_c; nu_reg <= nu_c;
                end
                rpnh_pkg::OP_DIV_INIT: begin
                    num_reg <= {nt_reg[XB-2:0], {FB{1'b0}}, 1'b0} >> 1;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CNTB'(NB);
                end
                rpnh_pkg::OP_DIV_STEP: begin
                    num_reg <= {num_reg[NB-2:0], 1'b0};
                    if (!rem_sub[XB]) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[NB-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
                rpnh_pkg::OP_UPDATE: begin
                    if (!any_hit_reg || t_sat < best_reg) begin
                        best_reg <= t_sat;
                        any_hit_reg <= 1'b1;
                    end
                end
                rpnh_pkg::OP_SQRT_INIT: begin
                    sq_n_reg   <= L2'(unsigned'(p_reg[6])) + L2'(unsigned'(p_reg[7]));
                    sq_res_reg <= '0;
                    sq_bit_reg <= L2'(1) << (2 * ((L2 - 1) / 2));
                end
                rpnh_pkg::OP_SQRT_STEP: begin
                    if (sq_n_reg >= sq_trial) begin
                        sq_n_reg   <= sq_n_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[1:0] != 2'b00)
                        len_reg <= LB'(sq_n_reg >= sq_trial ?
                                       (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1);
                end
                // low half of t first, then the high half added in above it
                rpnh_pkg::OP_FINAL_MUL: begin
                    if (!cmd.sel[0])
                        fin_reg[cmd.sel[2:1]] <= (TB+CB+2)'(fprod);
                    else
                        fin_reg[cmd.sel[2:1]] <= fin_reg[cmd.sel[2:1]]
                                                 + ((TB+CB+2)'(fprod) <<< HB);
                end
                rpnh_pkg::OP_OUTPUT: begin
                    if (!any_hit_reg) out_reg <= '0;
                    else begin
                        out_reg[0] <= 1'b1;
                        out_reg[CB:1] <= sat_s(hx);
                        out_reg[2*CB:CB+1] <= sat_s(hy);
                        out_reg[3*CB:2*CB+1] <= (|hd[TB+CB+1:CB]) ?
                                                {CB{1'b1}} : hd[CB-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.accept_edge = (den_reg != '0) && !nt_reg[XB-1] && !nu_reg[XB-1]
                              && (nu_reg <= den_reg);
    assign stat.div_done  = (cnt_reg == '0);
    assign stat.sqrt_done = (sq_bit_reg == '0);
    assign stat.any_hit   = any_hit_reg;
    assign out_data = out_reg;
endmodule

FILE: design/rpnh_ctrl.sv
`timescale 1ns / 1ps
module rpnh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_last,
    output logic            out_valid,
    input  logic            out_ready,
    output rpnh_pkg::cmd_t  cmd,
    input  rpnh_pkg::stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CLASS, S_TEST, S_DIV, S_UPD, S_LMUL, S_SQI, S_SQ,
        S_FMUL, S_OUT, S_HOLD
    } state_t;

    state_t     state_reg;
    logic [2:0] sel_reg;
    logic       last_reg, out_valid_reg;
    logic       out_free;

    // output register can take a new word
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // commands decoded from state
    always_comb begin
        cmd.sel = sel_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = (in_valid && in_ready) ? rpnh_pkg::OP_LOAD : rpnh_pkg::OP_NONE;
            S_MUL:   cmd.op = rpnh_pkg::OP_MUL;
            S_CLASS: cmd.op = rpnh_pkg::OP_CLASSIFY;
            S_TEST:  cmd.op = stat.accept_edge ? rpnh_pkg::OP_DIV_INIT : rpnh_pkg::OP_NONE;
            S_DIV:   cmd.op = stat.div_done ? rpnh_pkg::OP_NONE : rpnh_pkg::OP_DIV_STEP;
            S_UPD:   cmd.op = rpnh_pkg::OP_UPDATE;
            S_LMUL:  cmd.op = rpnh_pkg::OP_MUL;
            S_SQI:   cmd.op = rpnh_pkg::OP_SQRT_INIT;
            S_SQ:    cmd.op = stat.sqrt_done ? rpnh_pkg::OP_NONE : rpnh_pkg::OP_SQRT_STEP;
            S_FMUL:  cmd.op = rpnh_pkg::OP_FINAL_MUL;
            S_OUT:   cmd.op = out_free ? rpnh_pkg::OP_OUTPUT : rpnh_pkg::OP_NONE;
            default: cmd.op = rpnh_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; sel_reg <= '0; last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    last_reg <= in_last; sel_reg <= '0; state_reg <= S_MUL;
                end
                S_MUL: begin
                    sel_reg <= sel_reg + 1'b1;
                    if (sel_reg == 3'd5) state_reg <= S_CLASS;
                end
                S_CLASS: state_reg <= S_TEST;
                S_TEST: state_reg <= stat.accept_edge ? S_DIV : S_HOLD;
                S_DIV: if (stat.div_done) state_reg <= S_UPD;
                S_UPD: state_reg <= S_HOLD;
                S_HOLD: begin
                    // length squared products go to product slots 6 and 7
                    sel_reg <= 3'd6;
                    state_reg <= !last_reg ? S_IDLE : (stat.any_hit ? S_LMUL : S_OUT);
                end
                S_LMUL: begin
                    sel_reg <= sel_reg + 1'b1;
                    if (sel_reg == 3'd7) state_reg <= S_SQI;
                end
                S_SQI: state_reg <= S_SQ;
                S_SQ: if (stat.sqrt_done) begin
                    sel_reg <= '0; state_reg <= S_FMUL;
                end
                S_FMUL: begin
                    sel_reg <= sel_reg + 1'b1;
                    if (sel_reg == 3'd5) state_reg <= S_OUT;
                end
                S_OUT: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/ray_polygon_nearest_hit.sv
`timescale 1ns / 1ps
// Nearest hit of a ray against a polygon, one edge per input word.
// Slave channel: one word per edge; tuser[0] marks the first edge of a
// query (the ray fields are latched then), tlast marks the last edge.
// Master channel: one word after each last edge with the found flag,
// nearest hit point and distance (all zero when nothing was hit).
// The edge rate is set by the radix-2 divider, which runs one quotient bit
// per cycle over the 83-bit dividend for a hit edge; a skipped edge does
// not enter it, and a new edge is taken only after the last is done. The
// last edge adds the bit-pair square root of the direction length and the
// final products, which take t in two halves on a 25x33 multiplier.
// Products of the cross terms are formed one per cycle on a shared
// 33x33 multiplier.
// Reset clears the latched ray and the best hit; a query needs a first
// edge before it can hit anything.
// When the receiver stalls the result is held in the output register;
// edges keep being taken, and the next result waits until the held word
// has been delivered.
module ray_polygon_nearest_hit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ray_start_x, ray_start_y, ray_dir_x, ray_dir_y,
    // edge_a_x, edge_a_y, edge_b_x, edge_b_y
    input  logic [8*rpnh_pkg::COORD_BITS-1:0] s_tdata,
    input  logic [0:0]   s_tuser,   // first_edge
    input  logic         s_tlast,   // last_edge
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_found, hit_x, hit_y, hit_distance, zero padded
    output logic [3*rpnh_pkg::COORD_BITS+7:0] m_tdata
);
    rpnh_pkg::cmd_t  cmd;
    rpnh_pkg::stat_t stat;
    logic [3*rpnh_pkg::COORD_BITS:0] res;

    rpnh_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_last(s_tlast),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .stat
    );

    rpnh_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_data(s_tdata), .in_first(s_tuser[0]), .out_data(res)
    );

    assign m_tdata = {7'd0, res};
endmodule
